// ----- rtl/core/dnms_pkg.sv -----
`default_nettype none

package dnms_pkg;

    localparam int AXES       = 3;
    localparam int COUNT_BITS = 16;
    localparam int LANE_BITS  = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int DIV_STEPS  = 48;

    localparam logic [31:0] MASS_RST = 32'd65536;
    localparam logic [31:0] TIME_RST = 32'd65536;
    localparam logic [16:0] DAMP_RST = 17'd58982;

    typedef enum logic [2:0] {
        K_CLR_FORCE,
        K_ADD_FORCE,
        K_INTEGRATE,
        K_ACT_UP,
        K_ACT_DOWN,
        K_SET_PIN,
        K_LOAD_POS,
        K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        CFG_MASS,
        CFG_TIME,
        CFG_DAMP
    } t_cfg_idx;

    typedef enum logic [2:0] {
        LOP_NONE,
        LOP_CLR_F,
        LOP_ADD_F,
        LOP_LOAD_P,
        LOP_CLR_V,
        LOP_INTEG
    } t_lane_op;

    typedef struct packed {
        t_lane_op op;
    } t_lane_ctl;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] tstep;
        logic [31:0] half_tt;
        logic [16:0] damping;
    } t_coef;

    typedef enum logic [2:0] {
        T_IDLE,
        T_HTT,
        T_START,
        T_LANES,
        T_MERGE,
        T_OUT
    } t_top_st;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_ACC,
        LS_T1,
        LS_T2,
        LS_DISP,
        LS_QSTART,
        LS_Q,
        LS_VEL
    } t_lane_st;

    typedef enum logic [2:0] {
        M_IDLE,
        M_SQ,
        M_ACC,
        M_ROOT,
        M_MUL
    } t_merge_st;

    // magnitude of a signed 32-bit value (most negative maps to 2^31)
    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    // sign + 48-bit magnitude to saturated signed 32
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [47:0] mag);
        logic [31:0] r;
        if (neg) begin
            if (mag > 48'h0000_8000_0000) r = 32'h8000_0000;
            else r = ~mag[31:0] + 32'd1;
        end else begin
            if (mag > 48'h0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
            else r = mag[31:0];
        end
        return $signed(r);
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic [31:0]        r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else r = s[31:0];
        return $signed(r);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dnms_div.sv -----
`default_nettype none

// (num << 16) / den, truncated, saturated; restoring, one bit per cycle
module dnms_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic        [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quo
);

    logic        r_busy;
    logic        r_fin;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [47:0] r_quo;
    logic [31:0] r_den;
    logic        r_neg;
    logic signed [31:0] r_res;

    logic [32:0] rem_sh;
    logic [31:0] n_rem;
    logic [47:0] n_quo;
    logic        q_bit;

    always_comb begin
        rem_sh = {r_rem, r_quo[47]};
        if (rem_sh >= {1'b0, r_den}) begin
            q_bit = 1'b1;
            n_rem = 32'(rem_sh - {1'b0, r_den});
        end else begin
            q_bit = 1'b0;
            n_rem = rem_sh[31:0];
        end
        n_quo = {r_quo[46:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                if (i_den == 32'd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 6'(dnms_pkg::DIV_STEPS);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[31];
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= {dnms_pkg::abs32(i_num), 16'd0};
            if (i_den == 32'd0) begin
                if (i_num == 32'sd0) r_res <= 32'sd0;
                else r_res <= i_num[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end else if (r_fin) begin
            r_res <= dnms_pkg::sat_mag(r_neg, r_quo);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_res;

endmodule

`default_nettype wire

// ----- rtl/core/dnms_lane.sv -----
`default_nettype none

// one axis: position, velocity, force sum and the integrate sequence
module dnms_lane (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dnms_pkg::t_lane_ctl i_ctl,
    input  wire dnms_pkg::t_coef     i_coef,
    input  wire logic signed [31:0]  i_vec,
    output logic signed [31:0]       o_pos,
    output logic signed [31:0]       o_vel,
    output logic                     o_done
);

    dnms_pkg::t_lane_st r_state, n_state;

    logic signed [31:0] r_pos, r_vel, r_force;
    logic signed [31:0] r_acc, r_t1, r_t2, r_disp, r_q;
    logic               r_done;

    logic               div_start, div_done;
    logic signed [31:0] div_num, div_quo;
    logic        [31:0] div_den;

    logic signed [31:0] mul_a;
    logic        [31:0] mul_b;
    logic        [63:0] mul_prod;
    logic signed [31:0] mul_res;
    logic signed [31:0] disp_n;

    dnms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        div_start = 1'b0;
        div_num   = r_disp;
        div_den   = i_coef.tstep;
        if (r_state == dnms_pkg::LS_IDLE) begin
            div_num   = r_force;
            div_den   = i_coef.mass;
            div_start = (i_ctl.op == dnms_pkg::LOP_INTEG);
        end else if (r_state == dnms_pkg::LS_QSTART) begin
            div_start = 1'b1;
        end
    end

    // single shared multiplier
    always_comb begin
        case (r_state)
            dnms_pkg::LS_T1: begin
                mul_a = r_vel;
                mul_b = i_coef.tstep;
            end
            dnms_pkg::LS_T2: begin
                mul_a = r_acc;
                mul_b = i_coef.half_tt;
            end
            default: begin
                mul_a = r_q;
                mul_b = {15'd0, i_coef.damping};
            end
        endcase
        mul_prod = dnms_pkg::abs32(mul_a) * mul_b;
        mul_res  = dnms_pkg::sat_mag(mul_a[31], mul_prod[63:16]);
        disp_n   = dnms_pkg::sat_add(r_t1, r_t2);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dnms_pkg::LS_IDLE:   if (i_ctl.op == dnms_pkg::LOP_INTEG) n_state = dnms_pkg::LS_ACC;
            dnms_pkg::LS_ACC:    if (div_done) n_state = dnms_pkg::LS_T1;
            dnms_pkg::LS_T1:     n_state = dnms_pkg::LS_T2;
            dnms_pkg::LS_T2:     n_state = dnms_pkg::LS_DISP;
            dnms_pkg::LS_DISP:   n_state = dnms_pkg::LS_QSTART;
            dnms_pkg::LS_QSTART: n_state = dnms_pkg::LS_Q;
            dnms_pkg::LS_Q:      if (div_done) n_state = dnms_pkg::LS_VEL;
            dnms_pkg::LS_VEL:    n_state = dnms_pkg::LS_IDLE;
            default:             n_state = dnms_pkg::LS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnms_pkg::LS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == dnms_pkg::LS_VEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_vel   <= '0;
            r_force <= '0;
        end else begin
            case (i_ctl.op)
                dnms_pkg::LOP_CLR_F:  r_force <= '0;
                dnms_pkg::LOP_ADD_F:  r_force <= dnms_pkg::sat_add(r_force, i_vec);
                dnms_pkg::LOP_LOAD_P: r_pos   <= i_vec;
                dnms_pkg::LOP_CLR_V:  r_vel   <= '0;
                default: ;
            endcase
            if (r_state == dnms_pkg::LS_DISP) r_pos <= dnms_pkg::sat_add(r_pos, disp_n);
            if (r_state == dnms_pkg::LS_VEL)  r_vel <= mul_res;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dnms_pkg::LS_ACC:  if (div_done) r_acc <= div_quo;
            dnms_pkg::LS_T1:   r_t1 <= mul_res;
            dnms_pkg::LS_T2:   r_t2 <= mul_res;
            dnms_pkg::LS_DISP: r_disp <= disp_n;
            dnms_pkg::LS_Q:    if (div_done) r_q <= div_quo;
            default: ;
        endcase
    end

    assign o_pos  = r_pos;
    assign o_vel  = r_vel;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- rtl/core/dnms_merge.sv -----
`default_nettype none

// sum of squares over lanes, integer root, times mass
module dnms_merge (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_vel [dnms_pkg::AXES],
    input  wire logic        [31:0] i_mass,
    output logic                    o_done,
    output logic             [31:0] o_energy
);

    dnms_pkg::t_merge_st r_state, n_state;

    logic [dnms_pkg::LANE_BITS-1:0] r_idx;
    logic [63:0] r_sq, r_sum, r_x, r_res, r_bit;
    logic [31:0] r_energy;
    logic        r_done;

    logic [31:0] mag;
    logic [64:0] sum_w;
    logic [63:0] n_sum, trial;
    logic [63:0] prod;
    logic        last_lane;

    always_comb begin
        mag       = dnms_pkg::abs32(i_vel[r_idx]);
        sum_w     = {1'b0, r_sum} + {1'b0, r_sq};
        n_sum     = sum_w[64] ? '1 : sum_w[63:0];
        trial     = r_res + r_bit;
        prod      = i_mass * r_res[31:0];
        last_lane = (r_idx == dnms_pkg::LANE_BITS'(dnms_pkg::AXES - 1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dnms_pkg::M_IDLE: if (i_start) n_state = dnms_pkg::M_SQ;
            dnms_pkg::M_SQ:   n_state = dnms_pkg::M_ACC;
            dnms_pkg::M_ACC:  n_state = last_lane ? dnms_pkg::M_ROOT : dnms_pkg::M_SQ;
            dnms_pkg::M_ROOT: if (r_bit[0]) n_state = dnms_pkg::M_MUL;
            dnms_pkg::M_MUL:  n_state = dnms_pkg::M_IDLE;
            default:          n_state = dnms_pkg::M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnms_pkg::M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == dnms_pkg::M_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dnms_pkg::M_IDLE: begin
                r_idx <= '0;
                r_sum <= '0;
            end
            dnms_pkg::M_SQ: r_sq <= mag * mag;
            dnms_pkg::M_ACC: begin
                r_sum <= n_sum;
                r_idx <= r_idx + dnms_pkg::LANE_BITS'(1);
                r_x   <= n_sum;
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            dnms_pkg::M_ROOT: begin
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            dnms_pkg::M_MUL: r_energy <= (|prod[63:48]) ? '1 : prod[47:16];
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_energy = r_energy;

endmodule

`default_nettype wire

// ----- rtl/core/damped_node_motion_step_core.sv -----
`default_nettype none

// Motion state of one graph-layout node in signed Q16.16: position, velocity
// and force sum per axis, a pin flag and an activity count. Each input word
// yields one result word carrying energy, position and the two flags.
// Every kind except a live integrate (active and unpinned) completes in the
// accept cycle. In a live integrate one lane per axis runs in parallel, each
// doing F/mass and disp/t on its own 48-step bit-serial divider with
// multiplier steps between and a damping multiply after, then a merge unit
// squares and sums the velocities lane by lane, takes a 32-step integer
// root and scales by mass. Input is stalled while an integrate runs; a
// finished result waits in the output register while the next word is
// taken, unless that word would need the output register itself.
module damped_node_motion_step_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic        [2:0]  i_kind,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic               i_pin_value,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic             [31:0] o_energy,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic                    o_is_active,
    output logic                    o_is_pinned,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic        [1:0]  i_cfg_idx,
    input  wire logic        [31:0] i_cfg_data
);

    localparam int AXES = dnms_pkg::AXES;

    dnms_pkg::t_top_st r_state, n_state;

    // config and node state
    logic [31:0] r_mass, r_time, r_htt;
    logic [16:0] r_damp;
    logic [dnms_pkg::COUNT_BITS-1:0] r_cnt, n_cnt;
    logic        r_pin, n_pin;

    // output register
    logic        r_ov;
    logic [31:0] r_energy;
    logic signed [31:0] r_px, r_py, r_pz;
    logic        r_act, r_pinned;

    logic accept, movable, instant, slot_free, wr_out;
    dnms_pkg::t_kind     kind;
    dnms_pkg::t_lane_ctl lane_ctl;
    dnms_pkg::t_coef     coef;

    logic signed [31:0] vec  [AXES];
    logic signed [31:0] pos  [AXES];
    logic signed [31:0] vel  [AXES];
    logic [AXES-1:0]    lane_done;
    logic               lanes_done, merge_done;
    logic [31:0]        merge_energy;
    logic signed [31:0] pos_x, pos_y, pos_z;

    logic [63:0] tt;

    assign coef = '{mass: r_mass, tstep: r_time, half_tt: r_htt, damping: r_damp};

    // lanes: one per axis
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        if (g == 0) begin : g_x
            assign vec[g] = i_vec_x;
        end else if (g == 1) begin : g_y
            assign vec[g] = i_vec_y;
        end else if (g == 2) begin : g_z
            assign vec[g] = i_vec_z;
        end else begin : g_pad
            assign vec[g] = '0;
        end

        dnms_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_coef  (coef),
            .i_vec   (vec[g]),
            .o_pos   (pos[g]),
            .o_vel   (vel[g]),
            .o_done  (lane_done[g])
        );
    end

    assign pos_x = pos[0];
    assign pos_y = pos[1];
    if (AXES > 2) begin : g_has_z
        assign pos_z = pos[2];
    end else begin : g_no_z
        assign pos_z = '0;
    end

    assign lanes_done = &lane_done;

    dnms_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lanes_done),
        .i_vel    (vel),
        .i_mass   (r_mass),
        .o_done   (merge_done),
        .o_energy (merge_energy)
    );

    // t*t/2 in Q16.16, saturated
    assign tt = r_time * r_time;

    // accept / control
    always_comb begin
        kind      = dnms_pkg::t_kind'(i_kind);
        movable   = (r_cnt != '0) && !r_pin;
        instant   = !((kind == dnms_pkg::K_INTEGRATE) && movable);
        slot_free = !r_ov || !i_stall;
        o_stall   = (r_state != dnms_pkg::T_IDLE) || (instant && !slot_free);
        accept    = i_valid && !o_stall;

        n_cnt       = r_cnt;
        n_pin       = r_pin;
        lane_ctl.op = dnms_pkg::LOP_NONE;

        if (r_state == dnms_pkg::T_START) lane_ctl.op = dnms_pkg::LOP_INTEG;

        if (accept) begin
            case (kind)
                dnms_pkg::K_CLR_FORCE: lane_ctl.op = dnms_pkg::LOP_CLR_F;
                dnms_pkg::K_ADD_FORCE: if (movable) lane_ctl.op = dnms_pkg::LOP_ADD_F;
                dnms_pkg::K_ACT_UP: begin
                    if (r_cnt != '1) n_cnt = r_cnt + dnms_pkg::COUNT_BITS'(1);
                end
                dnms_pkg::K_ACT_DOWN: begin
                    if (r_cnt != '0) n_cnt = r_cnt - dnms_pkg::COUNT_BITS'(1);
                    if (n_cnt == '0) lane_ctl.op = dnms_pkg::LOP_CLR_V;
                end
                dnms_pkg::K_SET_PIN: begin
                    n_pin = i_pin_value;
                    if (!i_pin_value) lane_ctl.op = dnms_pkg::LOP_CLR_V;
                end
                dnms_pkg::K_LOAD_POS:  lane_ctl.op = dnms_pkg::LOP_LOAD_P;
                default: ;
            endcase
        end

        wr_out = (accept && instant) || ((r_state == dnms_pkg::T_OUT) && slot_free);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dnms_pkg::T_IDLE:  if (accept && !instant) n_state = dnms_pkg::T_HTT;
            dnms_pkg::T_HTT:   n_state = dnms_pkg::T_START;
            dnms_pkg::T_START: n_state = dnms_pkg::T_LANES;
            dnms_pkg::T_LANES: if (lanes_done) n_state = dnms_pkg::T_MERGE;
            dnms_pkg::T_MERGE: if (merge_done) n_state = dnms_pkg::T_OUT;
            dnms_pkg::T_OUT:   if (slot_free) n_state = dnms_pkg::T_IDLE;
            default:           n_state = dnms_pkg::T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnms_pkg::T_IDLE;
            r_cnt   <= '0;
            r_pin   <= 1'b0;
            r_ov    <= 1'b0;
            r_mass  <= dnms_pkg::MASS_RST;
            r_time  <= dnms_pkg::TIME_RST;
            r_damp  <= dnms_pkg::DAMP_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pin   <= n_pin;
            if (wr_out) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (i_cfg_we) begin
                unique case (dnms_pkg::t_cfg_idx'(i_cfg_idx))
                    dnms_pkg::CFG_MASS: r_mass <= i_cfg_data;
                    dnms_pkg::CFG_TIME: r_time <= i_cfg_data;
                    dnms_pkg::CFG_DAMP: r_damp <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == dnms_pkg::T_HTT) r_htt <= (|tt[63:49]) ? '1 : tt[48:17];
        if (wr_out) begin
            if (r_state == dnms_pkg::T_OUT) begin
                r_energy <= merge_energy;
                r_px     <= pos_x;
                r_py     <= pos_y;
                r_pz     <= pos_z;
                r_act    <= (r_cnt != '0);
                r_pinned <= r_pin;
            end else begin
                // word finishing in its accept cycle: loads show the new value
                r_energy <= '0;
                if (kind == dnms_pkg::K_LOAD_POS) begin
                    r_px <= i_vec_x;
                    r_py <= (AXES > 1) ? i_vec_y : 32'sd0;
                    r_pz <= (AXES > 2) ? i_vec_z : 32'sd0;
                end else begin
                    r_px <= pos_x;
                    r_py <= pos_y;
                    r_pz <= pos_z;
                end
                r_act    <= (n_cnt != '0);
                r_pinned <= n_pin;
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_energy    = r_energy;
    assign o_pos_x     = r_px;
    assign o_pos_y     = r_py;
    assign o_pos_z     = r_pz;
    assign o_is_active = r_act;
    assign o_is_pinned = r_pinned;

`ifndef SYNTHESIS
    a_lanes_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lanes_done |-> (r_state == dnms_pkg::T_LANES))
        else $error("lane finished outside integrate sequence");

    a_merge_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        merge_done |-> (r_state == dnms_pkg::T_MERGE))
        else $error("merge finished outside integrate sequence");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> (r_state == dnms_pkg::T_IDLE))
        else $error("input taken while integrate busy");
`endif

endmodule

`default_nettype wire
